// File: rtl/wsd_pkg.sv
package wsd_pkg;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int LEN_W = 63;

    typedef struct packed {
        logic             item_kind;
        logic             final_fragment;
        logic [2:0]       reserved_bits;
        logic [3:0]       frame_opcode;
        logic             was_masked;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       payload_byte;
        logic             frame_last;
        logic             length_error;
    } res_t;

endpackage

// File: rtl/websocket_frame_deframer.sv
// WebSocket (RFC 6455) receive deframer. Takes one stream byte per cycle on
// in_valid/in_stall and returns one header result per frame plus one unmasked
// result per payload byte on out_valid/out_stall; header bytes other than the
// one that completes the header, and payloads of frames whose 64-bit length has
// the top bit set, produce no result. Sustained rate is one byte per cycle while
// out_stall stays low, set by the single-pass parser; out_valid follows the accept
// through the input register, then a two-entry result buffer that lets the next
// byte in while a result waits to be taken.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       stream_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             item_kind,
    output logic             final_fragment,
    output logic [2:0]       reserved_bits,
    output logic [3:0]       frame_opcode,
    output logic             was_masked,
    output logic [LEN_W-1:0] payload_length,
    output logic [7:0]       payload_byte,
    output logic             frame_last,
    output logic             length_error
);

    logic       in_full_reg, in_full_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       accept;
    logic       space;
    logic       res_valid;
    res_t       res;
    res_t       out_data;

    assign advance  = in_full_reg && space;
    assign in_stall = in_full_reg && !space;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        priority if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && res_valid),
        .push_data (res),
        .has_space (space),
        .pop_valid (out_valid),
        .pop_stall (out_stall),
        .pop_data  (out_data)
    );

    assign item_kind      = out_data.item_kind;
    assign final_fragment = out_data.final_fragment;
    assign reserved_bits  = out_data.reserved_bits;
    assign frame_opcode   = out_data.frame_opcode;
    assign was_masked     = out_data.was_masked;
    assign payload_length = out_data.payload_length;
    assign payload_byte   = out_data.payload_byte;
    assign frame_last     = out_data.frame_last;
    assign length_error   = out_data.length_error;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && !space)
        else $error("input stalled without a blocked request");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !advance |=> in_full_reg)
        else $error("pending input byte dropped");

    a_stall_releases: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && out_valid && !out_stall |=> !in_stall || advance)
        else $error("input stall did not release after output drained");
`endif

endmodule

// File: rtl/wsd_parser.sv
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    output logic       res_valid,
    output res_t       res
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       flags_reg, flags_next;
    logic             mask_reg, mask_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [63:0]      acc_reg, acc_next;
    logic [31:0]      key_reg, key_next;
    logic [1:0]       mpos_reg, mpos_next;
    logic [LEN_W-1:0] rem_reg, rem_next;

    logic [6:0]       len7;
    logic [3:0]       cnt_dec;
    logic [LEN_W-1:0] rem_dec;
    logic [7:0]       key_byte;
    logic             hdr_done;
    logic             data_out;
    logic             data_last;

    assign len7    = byte_in[6:0];
    assign cnt_dec = cnt_reg - 4'd1;
    assign rem_dec = rem_reg - LEN_W'(1);

    always_comb
    begin
        unique case (mpos_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        mask_next  = mask_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        key_next   = key_reg;
        mpos_next  = mpos_reg;
        rem_next   = rem_reg;
        hdr_done   = 1'b0;
        data_out   = 1'b0;
        data_last  = 1'b0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                mask_next = byte_in[7];
                acc_next  = 64'd0;
                key_next  = 32'd0;
                mpos_next = 2'd0;
                if (len7 == 7'd126 || len7 == 7'd127)
                begin
                    cnt_next   = (len7 == 7'd126) ? 4'd2 : 4'd8;
                    phase_next = PH_EXT;
                end
                else
                begin
                    acc_next = {57'd0, len7};
                    if (byte_in[7])
                    begin
                        phase_next = PH_KEY;
                        cnt_next   = 4'd4;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_EXT:
            begin
                acc_next = {acc_reg[55:0], byte_in};
                cnt_next = cnt_dec;
                if (cnt_dec == 4'd0)
                begin
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                        cnt_next   = 4'd4;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], byte_in};
                cnt_next = cnt_dec;
                if (cnt_dec == 4'd0)
                begin
                    hdr_done = 1'b1;
                end
            end
            PH_DATA:
            begin
                mpos_next = mpos_reg + 2'd1;
                rem_next  = rem_dec;
                data_out  = 1'b1;
                data_last = (rem_dec == '0);
                if (data_last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            PH_SKIP:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                flags_next = byte_in;
                phase_next = PH_HDR1;
            end
        endcase

        // header complete: load the byte count and pick payload handling
        if (hdr_done)
        begin
            rem_next  = acc_next[LEN_W-1:0];
            mpos_next = 2'd0;
            if (acc_next[LEN_W-1:0] == '0)
            begin
                phase_next = PH_HDR0;
            end
            else
            begin
                phase_next = acc_next[63] ? PH_SKIP : PH_DATA;
            end
        end
    end

    always_comb
    begin
        res_valid          = hdr_done || data_out;
        res.item_kind      = data_out ? KIND_PAYLOAD : KIND_HEADER;
        res.final_fragment = flags_reg[7];
        res.reserved_bits  = flags_reg[6:4];
        res.frame_opcode   = flags_reg[3:0];
        res.was_masked     = mask_next;
        res.payload_length = acc_next[LEN_W-1:0];
        res.payload_byte   = data_out ? (byte_in ^ key_byte) : 8'd0;
        res.frame_last     = data_out ? data_last : (acc_next[LEN_W-1:0] == '0);
        res.length_error   = hdr_done && acc_next[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            flags_reg <= 8'd0;
            mask_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
            acc_reg   <= 64'd0;
            key_reg   <= 32'd0;
            mpos_reg  <= 2'd0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            mask_reg  <= mask_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            key_reg   <= key_next;
            mpos_reg  <= mpos_next;
            rem_reg   <= rem_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.item_kind == KIND_PAYLOAD |-> phase_reg == PH_DATA)
        else $error("payload result outside data phase");

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_SKIP |-> !res_valid)
        else $error("result produced while skipping bad-length payload");

    a_open_frame_enters_data: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.item_kind == KIND_HEADER && !res.frame_last
        && !res.length_error |=> phase_reg == PH_DATA && mpos_reg == 2'd0)
        else $error("header with payload did not enter data phase");

    a_last_returns_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.frame_last |=> phase_reg == PH_HDR0)
        else $error("frame end did not return to header parsing");
`endif

endmodule

// File: rtl/wsd_out_fifo.sv
module wsd_out_fifo
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic has_space,
    output logic pop_valid,
    input  logic pop_stall,
    output res_t pop_data
);

    res_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign has_space = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop       = pop_valid && !pop_stall;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result pushed into full buffer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 |-> wr_ptr_reg != rd_ptr_reg)
        else $error("pointers disagree with count");
`endif

endmodule
